// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the heap core RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/btk_pkg.sv =====
// Types and constants for the bounded top-K min-heap core.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package btk_pkg;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    STAT_PUSHED   = 3'd0,
    STAT_EVICTED  = 3'd1,
    STAT_REJECTED = 3'd2,
    STAT_POPPED   = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    action_t     action;
    logic [63:0] key;
    logic [31:0] tag;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] out_key;
    logic [31:0] out_tag;
    logic [6:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] tag;
  } entry_t;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_RD_ROOT,
    DP_TAKE_ROOT,
    DP_LOAD_LAST,
    DP_RD_LEFT,
    DP_RD_RIGHT,
    DP_DN_MOVE,
    DP_DN_FIN,
    DP_UP_START,
    DP_RD_PARENT,
    DP_UP_MOVE,
    DP_UP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    set_status;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic root_le_key;
    logic has_child;
    logic dn_stop;
    logic at_root;
    logic up_stop;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT_RD,
    S_ROOT_TAKE,
    S_LAST_LOAD,
    S_DN_CHK,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_UP_START,
    S_UP_CHK,
    S_UP_CMP,
    S_FULL_RD,
    S_FULL_CMP,
    S_DONE
  } state_t;

endpackage

// ===== rtl/btk_ctrl.sv =====
// Sequencing state machine of the top-K heap core.
// Depends on btk_pkg and assert_macros.svh; drives the datapath by command.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module btk_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  btk_pkg::action_t   action,
  input  btk_pkg::dp_stat_t  stat,
  output btk_pkg::dp_cmd_t   cmd,
  output logic               busy,
  output logic               out_valid
);

  btk_pkg::state_t state_r, state_nxt;
  logic evict_r, evict_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btk_pkg::S_IDLE;
      evict_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      evict_r <= evict_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    evict_nxt      = evict_r;
    cmd.op         = btk_pkg::DP_NOP;
    cmd.set_status = 1'b0;
    cmd.status     = btk_pkg::STAT_PUSHED;
    unique case (state_r)
      btk_pkg::S_IDLE: begin
        if (start) begin
          cmd.op         = btk_pkg::DP_ACCEPT;
          cmd.set_status = 1'b1;
          evict_nxt      = 1'b0;
          if (action == btk_pkg::ACT_POP) begin
            if (stat.count_zero) begin
              cmd.status = btk_pkg::STAT_EMPTY;
              state_nxt  = btk_pkg::S_DONE;
            end else begin
              cmd.status = btk_pkg::STAT_POPPED;
              state_nxt  = btk_pkg::S_ROOT_RD;
            end
          end else if (stat.full) begin
            // Status is settled once the root has been compared.
            cmd.set_status = 1'b0;
            state_nxt      = btk_pkg::S_FULL_RD;
          end else begin
            cmd.status = btk_pkg::STAT_PUSHED;
            state_nxt  = btk_pkg::S_UP_START;
          end
        end
      end
      btk_pkg::S_ROOT_RD: begin
        cmd.op    = btk_pkg::DP_RD_ROOT;
        state_nxt = btk_pkg::S_ROOT_TAKE;
      end
      btk_pkg::S_ROOT_TAKE: begin
        cmd.op    = btk_pkg::DP_TAKE_ROOT;
        state_nxt = btk_pkg::S_LAST_LOAD;
      end
      btk_pkg::S_LAST_LOAD: begin
        cmd.op    = btk_pkg::DP_LOAD_LAST;
        state_nxt = btk_pkg::S_DN_CHK;
      end
      btk_pkg::S_DN_CHK: begin
        if (stat.has_child) begin
          cmd.op    = btk_pkg::DP_RD_LEFT;
          state_nxt = btk_pkg::S_DN_LEFT;
        end else begin
          cmd.op    = btk_pkg::DP_DN_FIN;
          state_nxt = evict_r ? btk_pkg::S_UP_START : btk_pkg::S_DONE;
        end
      end
      btk_pkg::S_DN_LEFT: begin
        cmd.op    = btk_pkg::DP_RD_RIGHT;
        state_nxt = btk_pkg::S_DN_RIGHT;
      end
      btk_pkg::S_DN_RIGHT: begin
        if (stat.dn_stop) begin
          cmd.op    = btk_pkg::DP_DN_FIN;
          state_nxt = evict_r ? btk_pkg::S_UP_START : btk_pkg::S_DONE;
        end else begin
          cmd.op    = btk_pkg::DP_DN_MOVE;
          state_nxt = btk_pkg::S_DN_CHK;
        end
      end
      btk_pkg::S_UP_START: begin
        cmd.op    = btk_pkg::DP_UP_START;
        state_nxt = btk_pkg::S_UP_CHK;
      end
      btk_pkg::S_UP_CHK: begin
        if (stat.at_root) begin
          cmd.op    = btk_pkg::DP_UP_FIN;
          state_nxt = btk_pkg::S_DONE;
        end else begin
          cmd.op    = btk_pkg::DP_RD_PARENT;
          state_nxt = btk_pkg::S_UP_CMP;
        end
      end
      btk_pkg::S_UP_CMP: begin
        if (stat.up_stop) begin
          cmd.op    = btk_pkg::DP_UP_FIN;
          state_nxt = btk_pkg::S_DONE;
        end else begin
          cmd.op    = btk_pkg::DP_UP_MOVE;
          state_nxt = btk_pkg::S_UP_CHK;
        end
      end
      btk_pkg::S_FULL_RD: begin
        cmd.op    = btk_pkg::DP_RD_ROOT;
        state_nxt = btk_pkg::S_FULL_CMP;
      end
      btk_pkg::S_FULL_CMP: begin
        cmd.set_status = 1'b1;
        if (stat.root_le_key) begin
          cmd.status = btk_pkg::STAT_EVICTED;
          evict_nxt  = 1'b1;
          state_nxt  = btk_pkg::S_ROOT_RD;
        end else begin
          cmd.status = btk_pkg::STAT_REJECTED;
          state_nxt  = btk_pkg::S_DONE;
        end
      end
      btk_pkg::S_DONE: begin
        state_nxt = btk_pkg::S_IDLE;
      end
      default: begin
        state_nxt = btk_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != btk_pkg::S_IDLE);
  assign out_valid = (state_r == btk_pkg::S_DONE);

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid && !busy)
  `ASSERT_IMPL(a_evict_path, clk, rst_n, state_r == btk_pkg::S_UP_START && !evict_r,
               $past(state_r) == btk_pkg::S_IDLE)

endmodule

// ===== rtl/btk_dpath.sv =====
// Datapath of the top-K heap core: heap memory, hole walker, count and result.
// Depends on btk_pkg and assert_macros.svh; steered by btk_ctrl commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module btk_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  btk_pkg::dp_cmd_t    cmd,
  input  btk_pkg::in_item_t   in_item,
  input  logic [6:0]          cap_cfg,
  output btk_pkg::dp_stat_t   stat,
  output btk_pkg::out_item_t  out_item
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int IW   = AW + 2;
  localparam int CMPW = (CW > 7) ? CW : 7;

  btk_pkg::entry_t mem [CAPACITY];
  btk_pkg::entry_t rdata_r;
  logic [AW-1:0]   raddr;

  logic [CW-1:0]   count_r;
  logic [AW-1:0]   hole_r;
  btk_pkg::entry_t new_r;
  btk_pkg::entry_t moved_r;
  btk_pkg::entry_t left_r;
  btk_pkg::status_t status_r;
  logic [63:0]     okey_r;
  logic [31:0]     otag_r;

  logic [IW-1:0]   child, right, count_x;
  logic [AW-1:0]   parent;
  logic            right_ok, take_right;
  btk_pkg::entry_t chosen;
  logic [AW-1:0]   chosen_idx;
  logic [CMPW-1:0] cap_x, eff_cap, count_c;

  assign count_x = IW'(count_r);
  assign child   = IW'({hole_r, 1'b1});
  assign right   = child + IW'(1);
  assign parent  = AW'((hole_r - AW'(1)) >> 1);

  // Right child wins a tie, as in the testbench's heap predictor.
  assign right_ok   = right < count_x;
  assign take_right = right_ok && (rdata_r.key <= left_r.key);
  assign chosen     = take_right ? rdata_r : left_r;
  assign chosen_idx = take_right ? right[AW-1:0] : child[AW-1:0];

  // Out-of-range capacity is clamped into [1, CAPACITY].
  assign cap_x   = CMPW'(cap_cfg);
  assign count_c = CMPW'(count_r);
  always_comb begin
    if (cap_x == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_x > CMPW'(CAPACITY)) begin
      eff_cap = CMPW'(CAPACITY);
    end else begin
      eff_cap = cap_x;
    end
  end

  always_comb begin
    stat.count_zero  = (count_r == '0);
    stat.full        = (count_c >= eff_cap);
    stat.root_le_key = (rdata_r.key <= new_r.key);
    stat.has_child   = (child < count_x);
    stat.dn_stop     = (moved_r.key <= chosen.key);
    stat.at_root     = (hole_r == '0);
    stat.up_stop     = (rdata_r.key <= new_r.key);
  end

  always_comb begin
    case (cmd.op)
      btk_pkg::DP_TAKE_ROOT: raddr = AW'(count_r - CW'(1));
      btk_pkg::DP_RD_LEFT:   raddr = child[AW-1:0];
      btk_pkg::DP_RD_RIGHT:  raddr = right[AW-1:0];
      btk_pkg::DP_RD_PARENT: raddr = parent;
      default:               raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    case (cmd.op)
      btk_pkg::DP_DN_MOVE: mem[hole_r] <= chosen;
      btk_pkg::DP_DN_FIN:  mem[hole_r] <= moved_r;
      btk_pkg::DP_UP_MOVE: mem[hole_r] <= rdata_r;
      btk_pkg::DP_UP_FIN:  mem[hole_r] <= new_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      case (cmd.op)
        btk_pkg::DP_TAKE_ROOT: count_r <= count_r - CW'(1);
        btk_pkg::DP_UP_START:  count_r <= count_r + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    case (cmd.op)
      btk_pkg::DP_ACCEPT: begin
        new_r.key <= in_item.key;
        new_r.tag <= in_item.tag;
        okey_r    <= '0;
        otag_r    <= '0;
      end
      btk_pkg::DP_TAKE_ROOT: begin
        okey_r <= rdata_r.key;
        otag_r <= rdata_r.tag;
      end
      btk_pkg::DP_LOAD_LAST: begin
        moved_r <= rdata_r;
        hole_r  <= '0;
      end
      btk_pkg::DP_RD_RIGHT: left_r <= rdata_r;
      btk_pkg::DP_DN_MOVE:  hole_r <= chosen_idx;
      btk_pkg::DP_UP_START: hole_r <= AW'(count_r);
      btk_pkg::DP_UP_MOVE:  hole_r <= parent;
      default: ;
    endcase
  end

  assign out_item.status      = status_r;
  assign out_item.out_key     = okey_r;
  assign out_item.out_tag     = otag_r;
  assign out_item.entry_count = 7'(count_r);

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, IW'(count_r) <= IW'(CAPACITY))
  `ASSERT_IMPL(a_dn_move_child, clk, rst_n, cmd.op == btk_pkg::DP_DN_MOVE, stat.has_child)
  `ASSERT_IMPL(a_up_move_parent, clk, rst_n, cmd.op == btk_pkg::DP_UP_MOVE, !stat.at_root)

endmodule

// ===== rtl/bounded_top_k_min_heap_core.sv =====
// Top level of the bounded top-K min-heap core: APB register, controller, datapath.
// Depends on btk_pkg, btk_ctrl and btk_dpath.
`timescale 1ns / 1ps
// This core keeps the K largest 64-bit keys pushed so far, each with a 32-bit
// tag, in an array binary min-heap held in a single-port-write, single-read
// memory of CAPACITY entries. An item is taken when start is high and busy is
// low; busy then stays high until the one result item for it has been shown
// on out_item for exactly one cycle with out_valid high. The receiver cannot
// stall, so it must take the result in that cycle. A pop on an empty heap
// goes from the accept state straight to the result state; a rejected push
// reads and compares the root; a push into a full heap that evicts the root
// walks down and then up the tree. Every heap level costs a memory read with
// a registered output, so each level of the walk down reads the left child,
// reads the right child, then compares and moves, and each level of the walk
// up reads the parent, then compares and moves. K is the capacity_in_use
// register at byte address 0, written over the APB port; the user must write
// it only while the core is idle, which the core does not enforce. A value of
// zero acts as one and a value above CAPACITY acts as CAPACITY. Lowering K
// below the number of held entries makes the heap count as full. No clearing
// pass is needed after reset, since only slots below the held count are used.
module bounded_top_k_min_heap_core #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  btk_pkg::in_item_t   in_item,
  output logic                out_valid,
  output btk_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [6:0] cap_r;
  logic       cfg_wr;

  btk_pkg::dp_cmd_t  cmd;
  btk_pkg::dp_stat_t stat;

  // Only register index zero exists; the upper address bit selects it.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= btk_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[6:0];
    end
  end

  btk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_item.action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  btk_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cap_cfg  (cap_r),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

// ===== tb/bounded_top_k_min_heap_core_tb.sv =====
// Testbench for bounded_top_k_min_heap_core: directed and random push/pop items
// checked against a heap predictor kept in the bench. Depends on btk_pkg and the core.
`timescale 1ns / 1ps
module bounded_top_k_min_heap_core_tb;

  localparam int HEAP_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  btk_pkg::in_item_t   in_item;
  logic                out_valid;
  btk_pkg::out_item_t  out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  bounded_top_k_min_heap_core #(.CAPACITY(HEAP_DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // The bench's own copy of the heap, its held count and the K register.
  logic [63:0] heap_key_copy [HEAP_DEPTH];
  logic [31:0] heap_tag_copy [HEAP_DEPTH];
  int          held_entries;
  logic [6:0]  k_setting;

  btk_pkg::out_item_t pending_results[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          idle_enabled = 1'b1;

  function automatic int active_k();
    int c;
    c = k_setting;
    if (c < 1) c = 1;
    if (c > HEAP_DEPTH) c = HEAP_DEPTH;
    return c;
  endfunction

  // Removes the root; the last entry fills the hole and sinks, preferring the
  // right child when both children hold equal keys.
  function automatic void remove_min(output logic [63:0] k, output logic [31:0] t);
    int hole;
    int child;
    logic [63:0] mk;
    logic [31:0] mt;
    hole = 0;
    k = heap_key_copy[0];
    t = heap_tag_copy[0];
    held_entries--;
    mk = heap_key_copy[held_entries];
    mt = heap_tag_copy[held_entries];
    forever begin
      child = 2 * hole + 1;
      if (child >= held_entries) break;
      if (child + 1 < held_entries && heap_key_copy[child + 1] <= heap_key_copy[child])
        child = child + 1;
      if (mk <= heap_key_copy[child]) break;
      heap_key_copy[hole] = heap_key_copy[child];
      heap_tag_copy[hole] = heap_tag_copy[child];
      hole = child;
    end
    heap_key_copy[hole] = mk;
    heap_tag_copy[hole] = mt;
  endfunction

  function automatic void add_entry(logic [63:0] k, logic [31:0] t);
    int hole;
    int parent;
    hole = held_entries;
    held_entries++;
    while (hole > 0) begin
      parent = (hole - 1) >> 1;
      if (heap_key_copy[parent] <= k) break;
      heap_key_copy[hole] = heap_key_copy[parent];
      heap_tag_copy[hole] = heap_tag_copy[parent];
      hole = parent;
    end
    heap_key_copy[hole] = k;
    heap_tag_copy[hole] = t;
  endfunction

  function automatic btk_pkg::out_item_t predict_heap_result(btk_pkg::in_item_t it);
    btk_pkg::out_item_t r;
    r = '0;
    if (it.action == btk_pkg::ACT_POP) begin
      if (held_entries == 0) begin
        r.status = btk_pkg::STAT_EMPTY;
      end else begin
        remove_min(r.out_key, r.out_tag);
        r.status = btk_pkg::STAT_POPPED;
      end
    end else if (held_entries < active_k()) begin
      add_entry(it.key, it.tag);
      r.status = btk_pkg::STAT_PUSHED;
    end else if (heap_key_copy[0] <= it.key) begin
      remove_min(r.out_key, r.out_tag);
      add_entry(it.key, it.tag);
      r.status = btk_pkg::STAT_EVICTED;
    end else begin
      r.status = btk_pkg::STAT_REJECTED;
    end
    r.entry_count = held_entries[6:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Every result strobe must match the oldest outstanding prediction.
  always @(posedge clk) begin
    btk_pkg::out_item_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        compare_field("status", 64'(e.status), 64'(out_item.status));
        compare_field("out_key", e.out_key, out_item.out_key);
        compare_field("out_tag", 64'(e.out_tag), 64'(out_item.out_tag));
        compare_field("entry_count", 64'(e.entry_count), 64'(out_item.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bounded_top_k_min_heap_core_tb: FAIL");
      $finish;
    end
  end

  // Presents one item and holds start until the core takes it. start is left
  // high when no idle gap follows, so back-to-back items never glitch it.
  task automatic send_item(btk_pkg::in_item_t it);
    int gap;
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_heap_result(it));
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy !== 1'b0);
  endtask

  // APB write of the K register, setup phase then access phase; only issued while the core is idle.
  task automatic write_k(logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    k_setting = v[6:0];
  endtask

  function automatic btk_pkg::in_item_t make_item(btk_pkg::action_t a, logic [63:0] k,
                                                   logic [31:0] t);
    btk_pkg::in_item_t it;
    it.action = a;
    it.key = k;
    it.tag = t;
    return it;
  endfunction

  function automatic logic [63:0] random_key();
    // Narrow keys often, so that ties and equal-to-root pushes are common.
    if ($urandom_range(0, 1) == 0) return 64'($urandom_range(0, 15));
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed_corners();
    send_item(make_item(btk_pkg::ACT_POP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_item(btk_pkg::ACT_PUSH, 64'd0, 32'd0));
    send_item(make_item(btk_pkg::ACT_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_item(btk_pkg::ACT_PUSH, 64'd7, 32'h1234_5678));
    send_item(make_item(btk_pkg::ACT_PUSH, 64'd7, 32'h8765_4321));
    repeat (5) send_item(make_item(btk_pkg::ACT_POP, {$urandom, $urandom}, $urandom));
    wait_idle();
    // A single slot: an equal key evicts, a smaller one is turned away.
    write_k(32'd1);
    send_item(make_item(btk_pkg::ACT_PUSH, 64'd100, 32'hA));
    send_item(make_item(btk_pkg::ACT_PUSH, 64'd100, 32'hB));
    send_item(make_item(btk_pkg::ACT_PUSH, 64'd99, 32'hC));
    send_item(make_item(btk_pkg::ACT_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 32'hD));
    wait_idle();
    // Zero behaves as one slot.
    write_k(32'd0);
    send_item(make_item(btk_pkg::ACT_PUSH, 64'd5, 32'hE));
    send_item(make_item(btk_pkg::ACT_POP, 64'd0, 32'd0));
    send_item(make_item(btk_pkg::ACT_POP, 64'd0, 32'd0));
    wait_idle();
  endtask

  task automatic test_lowered_capacity();
    write_k(32'd64);
    repeat (12) send_item(make_item(btk_pkg::ACT_PUSH, random_key(), $urandom));
    wait_idle();
    // K now sits below the held count, so the heap counts as full.
    write_k(32'd3);
    repeat (10) send_item(make_item(btk_pkg::ACT_PUSH, random_key(), $urandom));
    repeat (14) send_item(make_item(btk_pkg::ACT_POP, random_key(), $urandom));
    wait_idle();
  endtask

  task automatic run_random_phase(logic [31:0] k, int n, int pop_pct);
    write_k(k);
    repeat (n) begin
      if ($urandom_range(0, 99) < pop_pct)
        send_item(make_item(btk_pkg::ACT_POP, {$urandom, $urandom}, $urandom));
      else
        send_item(make_item(btk_pkg::ACT_PUSH, random_key(), $urandom));
    end
    wait_idle();
  endtask

  task automatic test_random_mix();
    run_random_phase(32'd64, 400, 20);
    run_random_phase(32'd127, 300, 35);
    run_random_phase(32'd2, 200, 25);
    run_random_phase(32'd5, 250, 40);
    run_random_phase(32'hFFFF_FF81, 200, 10);
    run_random_phase(32'd17, 250, 45);
  endtask

  task automatic test_no_idle_tail();
    idle_enabled = 1'b0;
    run_random_phase(32'd64, 400, 30);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'd0;
    pwdata <= 32'd0;
    held_entries = 0;
    k_setting = btk_pkg::CAP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_lowered_capacity();
    test_random_mix();
    test_no_idle_tail();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("bounded_top_k_min_heap_core_tb: PASS");
    end else begin
      $display("bounded_top_k_min_heap_core_tb: FAIL");
    end
    $finish;
  end
endmodule
